// ----- hw/rtl/i2cmwr_pkg.sv -----
`timescale 1ns / 1ps
package i2cmwr_pkg;

  localparam int WriteDepth = 16;
  localparam int WrIdxW = $clog2(WriteDepth);
  localparam int WrCntW = $clog2(WriteDepth + 1);
  localparam int HpW = 10;
  localparam int StW = 20;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_QUEUE = 2'd1,
    FUNC_START = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_TIMEOUT  = 2'd1,
    STS_ADDR_NAK = 2'd2,
    STS_DATA_NAK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_WDATA  = 2'd1,
    STG_ADDR_R = 2'd2,
    STG_RDATA  = 2'd3
  } stage_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_SDA, PH_START_SCL, PH_START_HOLD, PH_START_LOW,
    PH_BIT_SETUP, PH_BIT_RISE, PH_BIT_HIGH, PH_STOP_SETUP, PH_STOP_RISE,
    PH_STOP_HIGH, PH_STOP_FREE, PH_CLR_LOW, PH_CLR_HIGH, PH_CLR_SETUP,
    PH_CLR_RISE, PH_CLR_FREE
  } phase_t;

  // one classified tick handed from front to back
  typedef struct packed {
    func_t      func;
    logic       scl;
    logic       sda;
    logic [6:0] addr;
    logic [7:0] data_byte;
    logic [4:0] write_count;
    logic [7:0] read_count;
  } tick_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done;
    status_t    status;
  } res_t;

endpackage

// ----- hw/rtl/i2cmwr_front.sv -----
`timescale 1ns / 1ps
module i2cmwr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cmwr_pkg::tick_t   in_tick,
  output logic                q_valid,
  input  logic                q_ready,
  output i2cmwr_pkg::tick_t   q_tick
);

  i2cmwr_pkg::tick_t mem_r [i2cmwr_pkg::QDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  // two-entry queue decoupling input from sequencer
  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_tick   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/i2cmwr_back.sv -----
`timescale 1ns / 1ps
module i2cmwr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [19:0]         cfg_wdata,
  input  logic                q_valid,
  output logic                q_ready,
  input  i2cmwr_pkg::tick_t   q_tick,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cmwr_pkg::res_t    out_res
);

  localparam int HpW = i2cmwr_pkg::HpW;
  localparam int StW = i2cmwr_pkg::StW;

  logic [HpW-1:0] half_period_r;
  logic [StW-1:0] stretch_timeout_r;

  i2cmwr_pkg::phase_t phase_r, phase_nxt;
  i2cmwr_pkg::stage_t stage_r, stage_nxt;
  logic [HpW-1:0] ht_r, ht_nxt;
  logic [StW-1:0] st_r, st_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [i2cmwr_pkg::WrCntW-1:0] fill_r, fill_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [i2cmwr_pkg::WrCntW-1:0] wtot_r, wtot_nxt;
  logic [7:0] rtot_r, rtot_nxt;
  logic scl_r, scl_nxt, sda_r, sda_nxt;
  i2cmwr_pkg::status_t err_r, err_nxt;
  logic [7:0] store_r [i2cmwr_pkg::WriteDepth];
  logic [7:0] store_rd_r;
  logic [i2cmwr_pkg::WrIdxW-1:0] pre_idx;
  logic store_we;

  i2cmwr_pkg::res_t res, res_r;
  logic ov_r;
  logic step;

  logic [HpW-1:0] ht_inc;
  logic [StW-1:0] st_inc;
  logic dly_done, st_exp;
  logic [8:0] byte_p1;
  logic [i2cmwr_pkg::WrCntW-1:0] wc_sat;

  // step whenever the output register is free or being drained
  assign q_ready   = !ov_r || out_ready;
  assign step      = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  assign ht_inc   = ht_r + 1'b1;
  assign dly_done = ht_inc >= half_period_r;
  assign st_inc   = st_r + 1'b1;
  assign st_exp   = st_inc >= stretch_timeout_r;
  assign byte_p1  = {1'b0, byte_r} + 9'd1;
  assign wc_sat   = (q_tick.write_count > 5'(i2cmwr_pkg::WriteDepth))
                  ? i2cmwr_pkg::WrCntW'(i2cmwr_pkg::WriteDepth)
                  : i2cmwr_pkg::WrCntW'(q_tick.write_count);

  // the next write byte is fetched while the current one is on the bus
  assign pre_idx  = (stage_r == i2cmwr_pkg::STG_WDATA)
                  ? byte_p1[i2cmwr_pkg::WrIdxW-1:0] : '0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r     <= HpW'(5);
      stretch_timeout_r <= StW'(10000);
    end else if (cfg_we) begin
      if (cfg_idx) stretch_timeout_r <= cfg_wdata;
      else half_period_r <= cfg_wdata[HpW-1:0];
    end
  end

  // write byte store
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[fill_r[i2cmwr_pkg::WrIdxW-1:0]] <= q_tick.data_byte;
    end
    store_rd_r <= store_r[pre_idx];
  end

  // sequencer next state
  always_comb begin
    logic nack;
    logic [7:0] bsh;
    logic bsda;
    logic [1:0] act;
    nack = sh_r[0];
    phase_nxt = phase_r; stage_nxt = stage_r; ht_nxt = ht_r; st_nxt = st_r;
    bit_nxt = bit_r; byte_nxt = byte_r; sh_nxt = sh_r; fill_nxt = fill_r;
    addr_nxt = addr_r; wtot_nxt = wtot_r; rtot_nxt = rtot_r;
    scl_nxt = scl_r; sda_nxt = sda_r; err_nxt = err_r;
    store_we = 1'b0;
    res = '0;
    bsh = '0; bsda = 1'b0;
    act = 2'd0; // 1 begin byte, 2 begin stop, 3 begin start
    unique case (phase_r)
      i2cmwr_pkg::PH_IDLE: begin
        unique case (q_tick.func)
          i2cmwr_pkg::FUNC_QUEUE: begin
            if (fill_r < i2cmwr_pkg::WrCntW'(i2cmwr_pkg::WriteDepth)) begin
              store_we = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end
          i2cmwr_pkg::FUNC_START: begin
            addr_nxt = q_tick.addr;
            wtot_nxt = wc_sat;
            rtot_nxt = q_tick.read_count;
            fill_nxt = '0; err_nxt = i2cmwr_pkg::STS_OK; byte_nxt = '0;
            stage_nxt = (wc_sat != '0 || q_tick.read_count == 8'd0)
                      ? i2cmwr_pkg::STG_ADDR_W : i2cmwr_pkg::STG_ADDR_R;
            act = 2'd3;
          end
          i2cmwr_pkg::FUNC_CLEAR: begin
            sda_nxt = 1'b0; scl_nxt = 1'b1; bit_nxt = '0;
            err_nxt = i2cmwr_pkg::STS_OK;
            phase_nxt = i2cmwr_pkg::PH_CLR_LOW; ht_nxt = '0;
          end
          i2cmwr_pkg::FUNC_TICK: ;
          default: ;
        endcase
      end
      i2cmwr_pkg::PH_START_SDA: begin
        if (q_tick.sda) begin
          scl_nxt = 1'b0; st_nxt = '0; phase_nxt = i2cmwr_pkg::PH_START_SCL;
        end else begin
          st_nxt = st_inc;
          if (st_exp) begin err_nxt = i2cmwr_pkg::STS_TIMEOUT; act = 2'd2; end
        end
      end
      i2cmwr_pkg::PH_START_SCL: begin
        if (q_tick.scl) begin
          phase_nxt = i2cmwr_pkg::PH_START_HOLD; ht_nxt = '0;
        end else begin
          st_nxt = st_inc;
          if (st_exp) begin err_nxt = i2cmwr_pkg::STS_TIMEOUT; act = 2'd2; end
        end
      end
      i2cmwr_pkg::PH_START_HOLD: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin sda_nxt = 1'b1; phase_nxt = i2cmwr_pkg::PH_START_LOW; end
      end
      i2cmwr_pkg::PH_START_LOW: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin scl_nxt = 1'b1; act = 2'd1; end
      end
      i2cmwr_pkg::PH_BIT_SETUP: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin
          scl_nxt = 1'b0; st_nxt = '0; phase_nxt = i2cmwr_pkg::PH_BIT_RISE;
        end
      end
      i2cmwr_pkg::PH_BIT_RISE: begin
        if (q_tick.scl) begin
          if (bit_r < 4'd8 || stage_r != i2cmwr_pkg::STG_RDATA)
            sh_nxt = {sh_r[6:0], q_tick.sda};
          phase_nxt = i2cmwr_pkg::PH_BIT_HIGH; ht_nxt = '0;
        end else begin
          st_nxt = st_inc;
          if (st_exp) begin err_nxt = i2cmwr_pkg::STS_TIMEOUT; act = 2'd2; end
        end
      end
      i2cmwr_pkg::PH_BIT_HIGH: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin
          scl_nxt = 1'b1;
          if (bit_r < 4'd8) begin
            bit_nxt = bit_r + 1'b1;
            if (bit_r + 4'd1 < 4'd8)
              sda_nxt = (stage_r == i2cmwr_pkg::STG_RDATA) ? 1'b0 : ~sh_r[7];
            else
              sda_nxt = stage_r == i2cmwr_pkg::STG_RDATA && byte_p1 < {1'b0, rtot_r};
            phase_nxt = i2cmwr_pkg::PH_BIT_SETUP; ht_nxt = '0;
          end else begin
            unique case (stage_r)
              i2cmwr_pkg::STG_ADDR_W: begin
                if (nack) begin err_nxt = i2cmwr_pkg::STS_ADDR_NAK; act = 2'd2; end
                else if (wtot_r != '0) begin
                  stage_nxt = i2cmwr_pkg::STG_WDATA; byte_nxt = '0; act = 2'd1;
                end else if (rtot_r != 8'd0) begin
                  stage_nxt = i2cmwr_pkg::STG_ADDR_R; act = 2'd3;
                end else act = 2'd2;
              end
              i2cmwr_pkg::STG_WDATA: begin
                if (nack) begin err_nxt = i2cmwr_pkg::STS_DATA_NAK; act = 2'd2; end
                else begin
                  byte_nxt = byte_p1[7:0];
                  if (byte_p1 < 9'(wtot_r)) act = 2'd1;
                  else if (rtot_r != 8'd0) begin
                    stage_nxt = i2cmwr_pkg::STG_ADDR_R; act = 2'd3;
                  end else act = 2'd2;
                end
              end
              i2cmwr_pkg::STG_ADDR_R: begin
                if (nack) begin err_nxt = i2cmwr_pkg::STS_ADDR_NAK; act = 2'd2; end
                else begin
                  stage_nxt = i2cmwr_pkg::STG_RDATA; byte_nxt = '0; act = 2'd1;
                end
              end
              i2cmwr_pkg::STG_RDATA: begin
                res.read_valid = 1'b1;
                res.read_data  = sh_r;
                res.read_last  = byte_p1 >= {1'b0, rtot_r};
                byte_nxt = byte_p1[7:0];
                act = (byte_p1 < {1'b0, rtot_r}) ? 2'd1 : 2'd2;
              end
              default: ;
            endcase
          end
        end
      end
      i2cmwr_pkg::PH_STOP_SETUP: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin
          scl_nxt = 1'b0; st_nxt = '0; phase_nxt = i2cmwr_pkg::PH_STOP_RISE;
        end
      end
      i2cmwr_pkg::PH_STOP_RISE: begin
        if (!q_tick.scl) st_nxt = st_inc;
        if (q_tick.scl || st_exp) begin
          phase_nxt = i2cmwr_pkg::PH_STOP_HIGH; ht_nxt = '0;
        end
      end
      i2cmwr_pkg::PH_STOP_HIGH: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin sda_nxt = 1'b0; phase_nxt = i2cmwr_pkg::PH_STOP_FREE; end
      end
      i2cmwr_pkg::PH_STOP_FREE: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin
          phase_nxt = i2cmwr_pkg::PH_IDLE; res.done = 1'b1; res.status = err_r;
        end
      end
      i2cmwr_pkg::PH_CLR_LOW: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin scl_nxt = 1'b0; phase_nxt = i2cmwr_pkg::PH_CLR_HIGH; end
      end
      i2cmwr_pkg::PH_CLR_HIGH: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin
          bit_nxt = bit_r + 1'b1;
          if (bit_r + 4'd1 < 4'd9) begin
            scl_nxt = 1'b1; phase_nxt = i2cmwr_pkg::PH_CLR_LOW;
          end else begin
            sda_nxt = 1'b1; phase_nxt = i2cmwr_pkg::PH_CLR_SETUP;
          end
        end
      end
      i2cmwr_pkg::PH_CLR_SETUP: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin scl_nxt = 1'b0; phase_nxt = i2cmwr_pkg::PH_CLR_RISE; end
      end
      i2cmwr_pkg::PH_CLR_RISE: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin sda_nxt = 1'b0; phase_nxt = i2cmwr_pkg::PH_CLR_FREE; end
      end
      i2cmwr_pkg::PH_CLR_FREE: begin
        ht_nxt = dly_done ? '0 : ht_inc;
        if (dly_done) begin
          phase_nxt = i2cmwr_pkg::PH_IDLE; res.done = 1'b1;
          res.status = i2cmwr_pkg::STS_OK;
        end
      end
      default: phase_nxt = i2cmwr_pkg::PH_IDLE;
    endcase

    // shared follow-up actions
    unique case (act)
      2'd1: begin
        unique case (stage_nxt)
          i2cmwr_pkg::STG_ADDR_W: bsh = {addr_r, 1'b0};
          i2cmwr_pkg::STG_ADDR_R: bsh = {addr_r, 1'b1};
          i2cmwr_pkg::STG_WDATA:  bsh = store_rd_r;
          default: bsh = 8'd0;
        endcase
        bsda = (stage_nxt == i2cmwr_pkg::STG_RDATA) ? 1'b0 : ~bsh[7];
        sh_nxt = bsh; bit_nxt = '0; sda_nxt = bsda;
        phase_nxt = i2cmwr_pkg::PH_BIT_SETUP; ht_nxt = '0;
      end
      2'd2: begin
        sda_nxt = 1'b1; phase_nxt = i2cmwr_pkg::PH_STOP_SETUP; ht_nxt = '0;
      end
      2'd3: begin
        sda_nxt = 1'b0; st_nxt = '0; phase_nxt = i2cmwr_pkg::PH_START_SDA;
      end
      default: ;
    endcase

    res.scl_low = scl_nxt;
    res.sda_low = sda_nxt;
    res.busy    = phase_nxt != i2cmwr_pkg::PH_IDLE;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cmwr_pkg::PH_IDLE; stage_r <= i2cmwr_pkg::STG_ADDR_W;
      ht_r <= '0; st_r <= '0; bit_r <= '0; byte_r <= '0; sh_r <= '0;
      fill_r <= '0; addr_r <= '0; wtot_r <= '0; rtot_r <= '0;
      scl_r <= 1'b0; sda_r <= 1'b0; err_r <= i2cmwr_pkg::STS_OK;
    end else if (step) begin
      phase_r <= phase_nxt; stage_r <= stage_nxt;
      ht_r <= ht_nxt; st_r <= st_nxt; bit_r <= bit_nxt; byte_r <= byte_nxt;
      sh_r <= sh_nxt; fill_r <= fill_nxt; addr_r <= addr_nxt;
      wtot_r <= wtot_nxt; rtot_r <= rtot_nxt;
      scl_r <= scl_nxt; sda_r <= sda_nxt; err_r <= err_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (q_ready) begin
      ov_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

endmodule

// ----- hw/rtl/i2c_master_write_read_core.sv -----
`timescale 1ns / 1ps
// open-drain i2c master stepped by one tick item per microsecond
// in_ channel: each item carries the sampled scl/sda levels and a command
//   (tick, queue write byte, start write-read, bus clear); commands are
//   only acted on while the sequencer is idle
// out_ channel: one item per input item with the line drives, busy,
//   a received byte when one completes and done/status at the end
// cfg_ port: index 0 half_period, index 1 stretch_timeout
// path: an item passes the queue entry, then the sequencer step into the
//   output register, and is then valid on out_; one item per cycle
//   sustained while out_tready stays high, set by the sequencer step
//   behind a two-entry queue
// reset: sequencer idle, lines released, write queue empty, registers
//   back to half_period 5 and stretch_timeout 10000
// stall: out_tready low holds the output register; the queue fills to its
//   two entries and then in_tready drops, nothing is lost
module i2c_master_write_read_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // scl_in, sda_in, addr, data_byte, write_count, read_count, zero pad
  input  logic [31:0] in_tdata,
  // func
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_low, sda_low, busy_res, read_valid, read_data, read_last, done_res,
  // status
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [19:0] cfg_wdata
);

  i2cmwr_pkg::tick_t in_tick, q_tick;
  i2cmwr_pkg::res_t  res;
  logic q_valid, q_ready;

  // unpack input item
  always_comb begin
    in_tick.func        = i2cmwr_pkg::func_t'(in_tuser);
    in_tick.scl         = in_tdata[0];
    in_tick.sda         = in_tdata[1];
    in_tick.addr        = in_tdata[8:2];
    in_tick.data_byte   = in_tdata[16:9];
    in_tick.write_count = in_tdata[21:17];
    in_tick.read_count  = in_tdata[29:22];
  end

  i2cmwr_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready), .in_tick (in_tick),
    .q_valid, .q_ready, .q_tick
  );

  i2cmwr_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .q_valid, .q_ready, .q_tick,
    .out_valid (out_tvalid), .out_ready (out_tready), .out_res (res)
  );

  // pack result item
  assign out_tdata = {res.status, res.done, res.read_last, res.read_data,
                      res.read_valid, res.busy, res.sda_low, res.scl_low};

  // output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // done and a read byte never come together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && out_tdata[13]))
    else $error("done with read byte");
  // a finished transaction reports idle
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> !out_tdata[2])
    else $error("done while busy");

endmodule

// ----- test/i2c_master_write_read_checker.sv -----
`timescale 1ns / 1ps
module i2c_master_write_read_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [19:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output logic        pred_idle
);

  // shadow copy of the sequencer
  logic [i2cmwr_pkg::HpW-1:0] half_period;
  logic [i2cmwr_pkg::StW-1:0] stretch_limit;
  i2cmwr_pkg::phase_t phase;
  i2cmwr_pkg::stage_t stage;
  logic [9:0]     half_timer;
  logic [19:0]    stretch_timer;
  logic [3:0]     bit_idx;
  logic [7:0]     byte_idx;
  logic [7:0]     shreg;
  logic [7:0]     wr_store [i2cmwr_pkg::WriteDepth];
  logic [4:0]     wr_fill;
  logic [6:0]     tgt_addr;
  logic [4:0]     wr_total;
  logic [7:0]     rd_total;
  logic           scl_hold, sda_hold;
  logic [1:0]     err_code;
  logic           o_valid, o_last, o_done;
  logic [7:0]     o_data;
  i2cmwr_pkg::status_t o_status;

  i2cmwr_pkg::res_t line_q[$];

  function automatic logic half_elapsed();
    half_timer = half_timer + 10'd1;
    if (half_timer >= half_period) begin
      half_timer = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic stretch_over();
    stretch_timer = stretch_timer + 20'd1;
    return stretch_timer >= stretch_limit;
  endfunction

  function automatic void go_delay(i2cmwr_pkg::phase_t nxt);
    phase = nxt;
    half_timer = '0;
  endfunction

  function automatic void go_stop();
    sda_hold = 1'b1;
    go_delay(i2cmwr_pkg::PH_STOP_SETUP);
  endfunction

  function automatic void go_fail(i2cmwr_pkg::status_t code);
    err_code = code;
    go_stop();
  endfunction

  function automatic void go_start();
    sda_hold = 1'b0;
    stretch_timer = '0;
    phase = i2cmwr_pkg::PH_START_SDA;
  endfunction

  function automatic void go_bit();
    if (bit_idx < 4'd8) sda_hold = (stage == i2cmwr_pkg::STG_RDATA) ? 1'b0 : ~shreg[7];
    else sda_hold = (stage == i2cmwr_pkg::STG_RDATA) &&
                    (int'(byte_idx) + 1 < int'(rd_total));
    go_delay(i2cmwr_pkg::PH_BIT_SETUP);
  endfunction

  function automatic void go_byte();
    bit_idx = '0;
    case (stage)
      i2cmwr_pkg::STG_ADDR_W: shreg = {tgt_addr, 1'b0};
      i2cmwr_pkg::STG_ADDR_R: shreg = {tgt_addr, 1'b1};
      i2cmwr_pkg::STG_WDATA:
        shreg = (byte_idx < i2cmwr_pkg::WriteDepth) ? wr_store[byte_idx[3:0]] : 8'd0;
      default: shreg = '0;
    endcase
    go_bit();
  endfunction

  function automatic void writes_finished();
    if (rd_total > 0) begin
      stage = i2cmwr_pkg::STG_ADDR_R;
      go_start();
    end else go_stop();
  endfunction

  function automatic void byte_finished();
    logic nack;
    nack = shreg[0];
    case (stage)
      i2cmwr_pkg::STG_ADDR_W: begin
        if (nack) go_fail(i2cmwr_pkg::STS_ADDR_NAK);
        else if (wr_total > 0) begin
          stage = i2cmwr_pkg::STG_WDATA;
          byte_idx = '0;
          go_byte();
        end else writes_finished();
      end
      i2cmwr_pkg::STG_WDATA: begin
        if (nack) go_fail(i2cmwr_pkg::STS_DATA_NAK);
        else begin
          byte_idx = byte_idx + 8'd1;
          if (byte_idx < wr_total) go_byte();
          else writes_finished();
        end
      end
      i2cmwr_pkg::STG_ADDR_R: begin
        if (nack) go_fail(i2cmwr_pkg::STS_ADDR_NAK);
        else begin
          stage = i2cmwr_pkg::STG_RDATA;
          byte_idx = '0;
          go_byte();
        end
      end
      default: begin
        o_valid = 1'b1;
        o_data = shreg;
        o_last = int'(byte_idx) + 1 >= int'(rd_total);
        byte_idx = byte_idx + 8'd1;
        if (byte_idx < rd_total) go_byte();
        else go_stop();
      end
    endcase
  endfunction

  function automatic void clear_sequencer();
    half_period = 10'd5;
    stretch_limit = 20'd10000;
    phase = i2cmwr_pkg::PH_IDLE;
    stage = i2cmwr_pkg::STG_ADDR_W;
    half_timer = '0;
    stretch_timer = '0;
    bit_idx = '0;
    byte_idx = '0;
    shreg = '0;
    wr_fill = '0;
    tgt_addr = '0;
    wr_total = '0;
    rd_total = '0;
    scl_hold = 1'b0;
    sda_hold = 1'b0;
    err_code = '0;
    for (int i = 0; i < i2cmwr_pkg::WriteDepth; i++) wr_store[i] = '0;
  endfunction

  // one tick of the i2c sequencer, returns the line state after it
  function automatic i2cmwr_pkg::res_t sequencer_tick(i2cmwr_pkg::func_t fn,
                                                      logic [31:0] d);
    i2cmwr_pkg::res_t r;
    logic scl, sda;
    logic [4:0] wc;
    scl = d[0];
    sda = d[1];
    o_valid = 0;
    o_data = '0;
    o_last = 0;
    o_done = 0;
    o_status = i2cmwr_pkg::STS_OK;
    case (phase)
      i2cmwr_pkg::PH_IDLE: begin
        if (fn == i2cmwr_pkg::FUNC_QUEUE) begin
          if (wr_fill < i2cmwr_pkg::WriteDepth) begin
            wr_store[wr_fill[3:0]] = d[16:9];
            wr_fill = wr_fill + 5'd1;
          end
        end else if (fn == i2cmwr_pkg::FUNC_START) begin
          wc = d[21:17];
          if (wc > i2cmwr_pkg::WriteDepth) wc = 5'(i2cmwr_pkg::WriteDepth);
          tgt_addr = d[8:2];
          wr_total = wc;
          rd_total = d[29:22];
          wr_fill = '0;
          err_code = '0;
          byte_idx = '0;
          stage = (wr_total > 0 || rd_total == 0) ? i2cmwr_pkg::STG_ADDR_W
                                                  : i2cmwr_pkg::STG_ADDR_R;
          go_start();
        end else if (fn == i2cmwr_pkg::FUNC_CLEAR) begin
          sda_hold = 0;
          scl_hold = 1;
          bit_idx = '0;
          err_code = '0;
          go_delay(i2cmwr_pkg::PH_CLR_LOW);
        end
      end
      i2cmwr_pkg::PH_START_SDA: begin
        if (sda) begin
          scl_hold = 0;
          stretch_timer = '0;
          phase = i2cmwr_pkg::PH_START_SCL;
        end else if (stretch_over()) go_fail(i2cmwr_pkg::STS_TIMEOUT);
      end
      i2cmwr_pkg::PH_START_SCL: begin
        if (scl) go_delay(i2cmwr_pkg::PH_START_HOLD);
        else if (stretch_over()) go_fail(i2cmwr_pkg::STS_TIMEOUT);
      end
      i2cmwr_pkg::PH_START_HOLD: if (half_elapsed()) begin
        sda_hold = 1;
        go_delay(i2cmwr_pkg::PH_START_LOW);
      end
      i2cmwr_pkg::PH_START_LOW: if (half_elapsed()) begin
        scl_hold = 1;
        go_byte();
      end
      i2cmwr_pkg::PH_BIT_SETUP: if (half_elapsed()) begin
        scl_hold = 0;
        stretch_timer = '0;
        phase = i2cmwr_pkg::PH_BIT_RISE;
      end
      i2cmwr_pkg::PH_BIT_RISE: begin
        if (scl) begin
          if (bit_idx < 4'd8 || stage != i2cmwr_pkg::STG_RDATA) shreg = {shreg[6:0], sda};
          go_delay(i2cmwr_pkg::PH_BIT_HIGH);
        end else if (stretch_over()) go_fail(i2cmwr_pkg::STS_TIMEOUT);
      end
      i2cmwr_pkg::PH_BIT_HIGH: if (half_elapsed()) begin
        scl_hold = 1;
        if (bit_idx < 4'd8) begin
          bit_idx = bit_idx + 4'd1;
          go_bit();
        end else byte_finished();
      end
      i2cmwr_pkg::PH_STOP_SETUP: if (half_elapsed()) begin
        scl_hold = 0;
        stretch_timer = '0;
        phase = i2cmwr_pkg::PH_STOP_RISE;
      end
      // a timeout here just lets the stop go on
      i2cmwr_pkg::PH_STOP_RISE:
        if (scl || stretch_over()) go_delay(i2cmwr_pkg::PH_STOP_HIGH);
      i2cmwr_pkg::PH_STOP_HIGH: if (half_elapsed()) begin
        sda_hold = 0;
        go_delay(i2cmwr_pkg::PH_STOP_FREE);
      end
      i2cmwr_pkg::PH_STOP_FREE: if (half_elapsed()) begin
        phase = i2cmwr_pkg::PH_IDLE;
        o_done = 1;
        o_status = i2cmwr_pkg::status_t'(err_code);
      end
      i2cmwr_pkg::PH_CLR_LOW: if (half_elapsed()) begin
        scl_hold = 0;
        go_delay(i2cmwr_pkg::PH_CLR_HIGH);
      end
      i2cmwr_pkg::PH_CLR_HIGH: if (half_elapsed()) begin
        bit_idx = bit_idx + 4'd1;
        if (bit_idx < 4'd9) begin
          scl_hold = 1;
          go_delay(i2cmwr_pkg::PH_CLR_LOW);
        end else begin
          sda_hold = 1;
          go_delay(i2cmwr_pkg::PH_CLR_SETUP);
        end
      end
      i2cmwr_pkg::PH_CLR_SETUP: if (half_elapsed()) begin
        scl_hold = 0;
        go_delay(i2cmwr_pkg::PH_CLR_RISE);
      end
      i2cmwr_pkg::PH_CLR_RISE: if (half_elapsed()) begin
        sda_hold = 0;
        go_delay(i2cmwr_pkg::PH_CLR_FREE);
      end
      i2cmwr_pkg::PH_CLR_FREE: if (half_elapsed()) begin
        phase = i2cmwr_pkg::PH_IDLE;
        o_done = 1;
        o_status = i2cmwr_pkg::STS_OK;
      end
      default: phase = i2cmwr_pkg::PH_IDLE;
    endcase
    r.scl_low = scl_hold;
    r.sda_low = sda_hold;
    r.busy = phase != i2cmwr_pkg::PH_IDLE;
    r.read_valid = o_valid;
    r.read_data = o_data;
    r.read_last = o_last;
    r.done = o_done;
    r.status = o_status;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    pred_idle = 1'b1;
    clear_sequencer();
  end

  // predict on each accepted input item, compare on each accepted result item
  always @(posedge clk) begin
    i2cmwr_pkg::res_t e;
    if (!rst_n) begin
      clear_sequencer();
      line_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == 1'b0) half_period = cfg_wdata[i2cmwr_pkg::HpW-1:0];
        else stretch_limit = cfg_wdata;
      end
      if (in_tvalid && in_tready)
        line_q.push_back(sequencer_tick(i2cmwr_pkg::func_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        if (line_q.size() == 0) begin
          $error("result item %0h with nothing expected", out_tdata);
          fail_count++;
        end else begin
          e = line_q.pop_front();
          check_field("scl_low", e.scl_low, out_tdata[0]);
          check_field("sda_low", e.sda_low, out_tdata[1]);
          check_field("busy_res", e.busy, out_tdata[2]);
          check_field("read_valid", e.read_valid, out_tdata[3]);
          check_field("read_data", e.read_data, out_tdata[11:4]);
          check_field("read_last", e.read_last, out_tdata[12]);
          check_field("done_res", e.done, out_tdata[13]);
          check_field("status", e.status, out_tdata[15:14]);
        end
      end
    end
    pending = line_q.size();
    pred_idle = phase == i2cmwr_pkg::PH_IDLE;
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int StallLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [19:0] cfg_wdata = '0;

  int   fail_count, pending;
  logic pred_idle;

  int   sent_items = 0;
  int   snd_pct = 0, rcv_pct = 0;
  int   scl_low_pct = 0, sda_low_pct = 50;
  int   fill_known = 0;
  bit   idle_known = 1;
  int   quiet_cycles = 0;

  always #10 clk = ~clk;

  i2c_master_write_read_core DUT (.*);

  i2c_master_write_read_checker u_checker (.*);

  // receiver backpressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rcv_pct);

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("i2c_master_write_read_core verification failed");
      $finish;
    end
  end

  // drive one item and wait for its handshake; returns at the accepting edge
  task automatic send(i2cmwr_pkg::func_t fn, logic [6:0] addr, logic [7:0] db,
                      logic [4:0] wc, logic [7:0] rc);
    logic scl, sda;
    scl = $urandom_range(99) >= scl_low_pct;
    sda = $urandom_range(99) >= sda_low_pct;
    while ($urandom_range(99) < snd_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {2'b00, rc, wc, db, addr, sda, scl};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    // the shadow sequencer state here excludes this item; ticks and queue
    // items keep an idle sequencer idle
    idle_known = pred_idle &&
                 (fn == i2cmwr_pkg::FUNC_TICK || fn == i2cmwr_pkg::FUNC_QUEUE);
    @(posedge clk);
    sent_items++;
  endtask

  // plain tick, with the odd command thrown in while the bus is busy
  task automatic tick_item();
    int pick;
    pick = $urandom_range(99);
    if (pick == 0) begin
      send(i2cmwr_pkg::FUNC_QUEUE, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    end else if (pick == 1) begin
      send(i2cmwr_pkg::FUNC_START, 7'($urandom), 8'($urandom), 5'd0,
           8'($urandom_range(3)));
      fill_known = 0;
    end else if (pick == 2) begin
      send(i2cmwr_pkg::FUNC_CLEAR, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    end else begin
      send(i2cmwr_pkg::FUNC_TICK, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_to_idle();
    idle_known = 0;
    while (!idle_known) tick_item();
  endtask

  task automatic queue_bytes(int n);
    for (int i = 0; i < n; i++) begin
      send(i2cmwr_pkg::FUNC_QUEUE, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
      if (fill_known < i2cmwr_pkg::WriteDepth) fill_known++;
    end
  endtask

  task automatic write_read(logic [6:0] addr, logic [4:0] wc, logic [7:0] rc);
    send(i2cmwr_pkg::FUNC_START, addr, 8'($urandom), wc, rc);
    fill_known = 0;
    run_to_idle();
  endtask

  task automatic bus_clear();
    send(i2cmwr_pkg::FUNC_CLEAR, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    run_to_idle();
  endtask

  // wait for every result item, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_transaction();
    int kind, mode;
    int wc_max;
    logic [7:0] rc;
    mode = $urandom_range(3);
    snd_pct = (mode == 1) ? 73 : (mode == 3) ? 34 : 0;
    rcv_pct = (mode == 2) ? 73 : (mode == 3) ? 34 : 0;
    scl_low_pct = ($urandom_range(3) == 0) ? 15 : $urandom_range(3);
    sda_low_pct = 30 + 20 * $urandom_range(2);
    kind = $urandom_range(9);
    if (kind == 0) begin
      bus_clear();
    end else begin
      queue_bytes(($urandom_range(7) == 0) ? 17 : $urandom_range(5));
      wc_max = (fill_known >= i2cmwr_pkg::WriteDepth) ? 31 : fill_known;
      rc = ($urandom_range(9) == 0) ? 8'($urandom_range(12)) : 8'($urandom_range(3));
      if (kind == 1) write_read(7'($urandom), 5'd0, 8'd0);
      else write_read(7'($urandom), 5'($urandom_range(wc_max)), rc);
    end
  endtask

  initial begin
    int quota;
    int hp_set [6] = '{0, 1, 2, 3, 1, 7};
    int st_set [6] = '{0, 1, 3, 1048575, 10000, 2};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings first
    sda_low_pct = 50;
    bus_clear();
    write_read(7'd0, 5'd0, 8'd0);

    // extremes of the fields with queued writes, ticks and starts at a short half period
    drain();
    write_reg(1'b0, 20'd1);
    send(i2cmwr_pkg::FUNC_QUEUE, 7'd0, 8'h00, 5'd0, 8'd0);
    send(i2cmwr_pkg::FUNC_QUEUE, 7'd0, 8'hff, 5'd0, 8'd0);
    fill_known = 2;
    queue_bytes(15);
    write_read(7'h7f, 5'd31, 8'd2);
    queue_bytes(1);
    write_read(7'h55, 5'd1, 8'd1);
    write_read(7'h2a, 5'd0, 8'd1);
    // released data line: the address is refused before the longest read
    sda_low_pct = 0;
    write_read(7'h3c, 5'd0, 8'd255);
    sda_low_pct = 50;

    // pressure point: let the result channel empty out
    drain();

    for (int s = 0; s < 6; s++) begin
      drain();
      write_reg(1'b0, 20'(hp_set[s]));
      write_reg(1'b1, 20'(st_set[s]));
      if (s == 5) begin
        snd_pct = 0;
        rcv_pct = 0;
        scl_low_pct = 0;
        bus_clear();
      end else begin
        quota = sent_items + 80;
        while (sent_items < quota) random_transaction();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0) $display("i2c_master_write_read_core verification clean");
    else $display("i2c_master_write_read_core verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/i2cmwr_pkg.sv
hw/rtl/i2cmwr_front.sv
hw/rtl/i2cmwr_back.sv
hw/rtl/i2c_master_write_read_core.sv
test/i2c_master_write_read_checker.sv
test/testbench.sv
